// ===== hdl/m2bs_pkg.sv =====
// ----------------------------------------------------------------------------
// m2bs_pkg
// Shared constants and types for the MurmurHash2 bucket selector.
// ----------------------------------------------------------------------------
package m2bs_pkg;

  // Mixing constants of the 32-bit MurmurHash2 algorithm.
  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam int unsigned MIX_R     = 24;
  localparam int unsigned FIN_SH_A  = 13;
  localparam int unsigned FIN_SH_B  = 15;

  // Field widths.
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned NB_W      = 17;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest bucket count honoured; larger values are clamped to it.
  localparam logic [NB_W-1:0] MAX_BUCKETS = 17'd65536;
  localparam logic [NB_W-1:0] NB_RESET    = 17'd1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_SEED    = 1'b0,
    CFG_BUCKET_COUNT = 1'b1
  } cfg_reg_t;

  // Request to the iterative modulo unit.
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [NB_W-1:0]   divisor;
  } div_req_t;

  // Response from the iterative modulo unit.
  typedef struct packed {
    logic            done;
    logic [NB_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/m2bs_if.sv =====
// ----------------------------------------------------------------------------
// m2bs channel interfaces
// Valid/ready channels for key bytes, results and configuration writes.
// ----------------------------------------------------------------------------

// Key byte channel.
interface m2bs_in_if;
  logic                          valid;
  logic                          ready;
  logic [m2bs_pkg::BYTE_W-1:0]   key_byte;
  logic [m2bs_pkg::LEN_W-1:0]    key_length;
  logic                          last_byte;

  modport source (output valid, key_byte, key_length, last_byte, input ready);
  modport sink   (input valid, key_byte, key_length, last_byte, output ready);
endinterface

// Result channel.
interface m2bs_out_if;
  logic                          valid;
  logic                          ready;
  logic [m2bs_pkg::IDX_W-1:0]    bucket_index;
  logic [m2bs_pkg::HASH_W-1:0]   full_hash;

  modport source (output valid, bucket_index, full_hash, input ready);
  modport sink   (input valid, bucket_index, full_hash, output ready);
endinterface

// Configuration write channel.
interface m2bs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [m2bs_pkg::CFG_IDX_W-1:0] index;
  logic [m2bs_pkg::HASH_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/m2bs_mul.sv =====
// ----------------------------------------------------------------------------
// m2bs_mul
// Shared multiplier: registered low 32 bits of operand times the mix constant.
// ----------------------------------------------------------------------------
module m2bs_mul (
  input  logic                        clk,
  input  logic [m2bs_pkg::HASH_W-1:0] op_i,
  output logic [m2bs_pkg::HASH_W-1:0] prod_o
);

  logic [m2bs_pkg::HASH_W-1:0] prod_lo;
  logic [m2bs_pkg::HASH_W-1:0] prod_r;

  // Only the low word of the product is kept, as in modulo 2^32 arithmetic.
  assign prod_lo = op_i * m2bs_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    prod_r <= prod_lo;
  end

  assign prod_o = prod_r;

endmodule

// ===== hdl/m2bs_div.sv =====
// ----------------------------------------------------------------------------
// m2bs_div
// Iterative restoring modulo unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module m2bs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  m2bs_pkg::div_req_t req_i,
  output m2bs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(m2bs_pkg::HASH_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [m2bs_pkg::HASH_W-1:0] dvd_r;
  logic [m2bs_pkg::NB_W-1:0]   dvs_r;
  logic [m2bs_pkg::NB_W-1:0]   rem_r;
  logic [m2bs_pkg::NB_W:0]     trial;

  // Bring down the next dividend bit beside the partial remainder.
  assign trial = {rem_r, dvd_r[m2bs_pkg::HASH_W-1]};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(m2bs_pkg::HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one compare and subtract per cycle.
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      dvs_r <= req_i.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[m2bs_pkg::HASH_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= m2bs_pkg::NB_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[m2bs_pkg::NB_W-1:0];
      end
    end
  end

  assign rsp_o.done      = done_r;
  assign rsp_o.remainder = rem_r;

endmodule

// ===== hdl/murmur2_bucket_select_top.sv =====
// ----------------------------------------------------------------------------
// murmur2_bucket_select_top
// Streaming MurmurHash2 (32-bit) of a byte-wise key, reduced to a bucket index.
// ----------------------------------------------------------------------------
// Usage:
//   Key bytes arrive on in_ch, one per beat, in key order. The first beat of
//   a key carries the key length, which is XORed with the seed to start the
//   hash; last_byte marks the final beat. A key of length zero is a single
//   beat with last_byte set, whose byte is ignored.
//   On the final beat one result beat appears on out_ch with the full hash
//   and the hash modulo the bucket count; no other beat produces a result.
//   cfg_ch writes hash_seed (index 0) and bucket_count (index 1); it is always
//   ready. It must be written only while no key is in flight; the block itself does not enforce this.
// Sequencing:
//   A byte that does not complete a word is taken in S_IDLE. A byte that
//   completes a 4-byte word goes through S_W1 to S_W4, with three passes through
//   the single shared multiplier. After the final beat the finish mix runs
//   through S_F1 to S_F3, then the modulo unit finds one quotient bit a cycle
//   in S_DIV before the result is offered from S_OUT.
// Reset and stall:
//   rst_n clears the hash state and sets the seed to 0 and the bucket count
//   to 1024. A result waits in the output register while out_ch is stalled;
//   the next key is accepted meanwhile until its own result is due.
// ----------------------------------------------------------------------------
module murmur2_bucket_select_top (
  input  logic              clk,
  input  logic              rst_n,
  m2bs_in_if.sink           in_ch,
  m2bs_out_if.source        out_ch,
  m2bs_cfg_if.sink          cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_W1,
    S_W2,
    S_W3,
    S_W4,
    S_F1,
    S_F2,
    S_F3,
    S_DIV,
    S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [m2bs_pkg::HASH_W-1:0] seed_r;
  logic [m2bs_pkg::NB_W-1:0]   nb_r;
  logic [m2bs_pkg::HASH_W-1:0] acc_r, acc_nxt;
  logic [23:0]                 wa_r, wa_nxt;
  logic [1:0]                  biw_r, biw_nxt;
  logic                        inside_r, inside_nxt;
  logic                        last_r, last_nxt;
  logic [m2bs_pkg::HASH_W-1:0] kreg_r, kreg_nxt;
  logic [m2bs_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic                        ov_r, ov_nxt;
  logic [m2bs_pkg::IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [m2bs_pkg::HASH_W-1:0] ohash_r, ohash_nxt;

  logic [m2bs_pkg::HASH_W-1:0] mul_op;
  logic [m2bs_pkg::HASH_W-1:0] mul_prod;
  m2bs_pkg::div_req_t          div_req;
  m2bs_pkg::div_rsp_t          div_rsp;

  logic                        in_acc;
  logic                        first;
  logic                        take;
  logic [m2bs_pkg::HASH_W-1:0] acc_base;
  logic [23:0]                 wa_base;
  logic [1:0]                  biw_base;
  logic [m2bs_pkg::HASH_W-1:0] fin_x;
  logic [m2bs_pkg::HASH_W-1:0] fin_h;
  logic [m2bs_pkg::NB_W-1:0]   nb_eff;
  logic                        slot_free;

  // Shared multiplier and modulo unit.
  m2bs_mul u_mul (
    .clk    (clk),
    .op_i   (mul_op),
    .prod_o (mul_prod)
  );

  m2bs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Handshakes.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign slot_free    = !ov_r || out_ch.ready;

  assign out_ch.valid        = ov_r;
  assign out_ch.bucket_index = oidx_r;
  assign out_ch.full_hash    = ohash_r;

  // Starting values of a key on its first beat.
  assign first    = !inside_r;
  assign acc_base = first ? (seed_r ^ {16'b0, in_ch.key_length}) : acc_r;
  assign wa_base  = first ? 24'b0 : wa_r;
  assign biw_base = first ? 2'b0 : biw_r;
  assign take     = !(first && (in_ch.key_length == '0));

  // Finish mix intermediates.
  assign fin_x = (biw_r != 2'b0) ? mul_prod : acc_r;
  assign fin_h = mul_prod ^ (mul_prod >> m2bs_pkg::FIN_SH_B);

  // Bucket count clamped to the supported range.
  always_comb begin
    if (nb_r == '0) begin
      nb_eff = m2bs_pkg::NB_W'(1);
    end else if (nb_r > m2bs_pkg::MAX_BUCKETS) begin
      nb_eff = m2bs_pkg::MAX_BUCKETS;
    end else begin
      nb_eff = nb_r;
    end
  end

  // Sequencer: next state, multiplier operand and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    wa_nxt     = wa_r;
    biw_nxt    = biw_r;
    inside_nxt = inside_r;
    last_nxt   = last_r;
    kreg_nxt   = kreg_r;
    hash_nxt   = hash_r;
    ov_nxt     = ov_r;
    oidx_nxt   = oidx_r;
    ohash_nxt  = ohash_r;
    mul_op     = kreg_r;
    div_req.start    = 1'b0;
    div_req.dividend = fin_h;
    div_req.divisor  = nb_eff;

    // A waiting result leaves when the receiver takes it.
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          acc_nxt    = acc_base;
          wa_nxt     = wa_base;
          biw_nxt    = biw_base;
          inside_nxt = 1'b1;
          last_nxt   = in_ch.last_byte;
          if (take && (biw_base == 2'd3)) begin
            // Fourth byte completes a word: mix it in.
            kreg_nxt  = {in_ch.key_byte, wa_base};
            wa_nxt    = 24'b0;
            biw_nxt   = 2'b0;
            state_nxt = S_W1;
          end else begin
            if (take) begin
              unique case (biw_base)
                2'd0:    wa_nxt = {wa_base[23:8], in_ch.key_byte};
                2'd1:    wa_nxt = {wa_base[23:16], in_ch.key_byte, wa_base[7:0]};
                default: wa_nxt = {in_ch.key_byte, wa_base[15:0]};
              endcase
              biw_nxt = biw_base + 2'd1;
            end
            if (in_ch.last_byte) begin
              state_nxt = S_F1;
            end
          end
        end
      end
      S_W1: begin
        mul_op    = kreg_r;
        state_nxt = S_W2;
      end
      S_W2: begin
        mul_op    = mul_prod ^ (mul_prod >> m2bs_pkg::MIX_R);
        state_nxt = S_W3;
      end
      S_W3: begin
        kreg_nxt  = mul_prod;
        mul_op    = acc_r;
        state_nxt = S_W4;
      end
      S_W4: begin
        acc_nxt   = mul_prod ^ kreg_r;
        state_nxt = last_r ? S_F1 : S_IDLE;
      end
      S_F1: begin
        // Tail bytes are folded in only when some remain.
        mul_op    = acc_r ^ {8'b0, wa_r};
        state_nxt = S_F2;
      end
      S_F2: begin
        mul_op    = fin_x ^ (fin_x >> m2bs_pkg::FIN_SH_A);
        state_nxt = S_F3;
      end
      S_F3: begin
        hash_nxt      = fin_h;
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          oidx_nxt   = div_rsp.remainder[m2bs_pkg::IDX_W-1:0];
          ohash_nxt  = hash_r;
          acc_nxt    = '0;
          wa_nxt     = 24'b0;
          biw_nxt    = 2'b0;
          inside_nxt = 1'b0;
          last_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, hash state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_r    <= '0;
      wa_r     <= 24'b0;
      biw_r    <= 2'b0;
      inside_r <= 1'b0;
      last_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      wa_r     <= wa_nxt;
      biw_r    <= biw_nxt;
      inside_r <= inside_nxt;
      last_r   <= last_nxt;
      ov_r     <= ov_nxt;
    end
    kreg_r  <= kreg_nxt;
    hash_r  <= hash_nxt;
    oidx_r  <= oidx_nxt;
    ohash_r <= ohash_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      nb_r   <= m2bs_pkg::NB_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        m2bs_pkg::CFG_HASH_SEED:    seed_r <= cfg_ch.data;
        m2bs_pkg::CFG_BUCKET_COUNT: nb_r   <= cfg_ch.data[m2bs_pkg::NB_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MurmurHash2 bucket selector. Keys are sent
// one byte per beat while a behavioural model hashes every accepted beat and
// queues the expected hash and bucket index. Each result beat is checked
// against the oldest queued entry. Stimulus covers directed corner keys,
// extreme register settings, back-to-back traffic, a long output stall and
// many random keys under varying seeds and bucket counts.
// ----------------------------------------------------------------------------
module tb_top;
  import m2bs_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned ITEM_TARGET     = 1750;
  localparam int unsigned MAX_REPORTS     = 50;

  // Register settings at and beyond the limits of the bucket count.
  localparam logic [HASH_W-1:0] EDGE_SEEDS [7] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h8000_0001,
    32'h0000_0001, 32'h7FFF_FFFF, 32'hDEAD_BEEF
  };
  localparam logic [HASH_W-1:0] EDGE_BUCKETS [7] = '{
    32'd1, 32'd65536, 32'd0, 32'd131071, 32'hFFFF_FFFF, 32'd65535, 32'd2
  };

  typedef struct packed {
    logic [IDX_W-1:0]  bucket_index;
    logic [HASH_W-1:0] full_hash;
  } bucket_pick_t;

  typedef logic [BYTE_W-1:0] key_bytes_t[$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  m2bs_in_if  in_ch ();
  m2bs_out_if out_ch ();
  m2bs_cfg_if cfg_ch ();

  murmur2_bucket_select_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model state and its copy of the registers.
  logic [HASH_W-1:0] seed_cfg;
  logic [NB_W-1:0]   buckets_cfg;
  logic [HASH_W-1:0] acc_hash;
  logic [23:0]       tail_bytes;
  logic [1:0]        tail_count;
  logic              key_open;

  bucket_pick_t pending_buckets[$];

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_taken;
  int unsigned hold_off_left;
  int unsigned stall_left;
  bit          steady_flow   = 1'b0;

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while steady_flow is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("check failed at %0t: %s", $time, what);
  endtask

  // Hash one accepted key beat; on the final beat queue the expected result.
  task automatic hash_key_beat(input logic [BYTE_W-1:0] kb, input logic [LEN_W-1:0] klen,
                               input logic last);
    logic [HASH_W-1:0] k;
    logic [HASH_W-1:0] h;
    logic [NB_W-1:0]   nb;
    bucket_pick_t      pick;
    bit                take;
    take = 1'b1;
    if (!key_open) begin
      acc_hash   = seed_cfg ^ {16'd0, klen};
      tail_bytes = '0;
      tail_count = '0;
      key_open   = 1'b1;
      // An empty key does not hash its first byte.
      take = (klen != '0);
    end
    if (take) begin
      if (tail_count != 2'd3) begin
        tail_bytes = tail_bytes | (24'(kb) << (8 * tail_count));
        tail_count = tail_count + 2'd1;
      end else begin
        k = {kb, tail_bytes} * MIX_MUL;
        k = k ^ (k >> MIX_R);
        k = k * MIX_MUL;
        acc_hash   = (acc_hash * MIX_MUL) ^ k;
        tail_bytes = '0;
        tail_count = '0;
      end
    end
    if (last) begin
      h = acc_hash;
      if (tail_count != '0) begin
        h = h ^ {8'd0, tail_bytes};
        h = h * MIX_MUL;
      end
      h = h ^ (h >> FIN_SH_A);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SH_B);
      // A zero count acts as one bucket; oversized counts are clamped.
      nb = buckets_cfg;
      if (nb == '0) nb = 17'd1;
      if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
      pick.full_hash    = h;
      pick.bucket_index = IDX_W'(h % {15'd0, nb});
      pending_buckets.push_back(pick);
      acc_hash   = '0;
      tail_bytes = '0;
      tail_count = '0;
      key_open   = 1'b0;
    end
  endtask

  // Model update on every accepted register write and key beat.
  always @(posedge clk) begin : predictor
    if (!rst_n) begin
      seed_cfg    = '0;
      buckets_cfg = NB_RESET;
      acc_hash    = '0;
      tail_bytes  = '0;
      tail_count  = '0;
      key_open    = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_HASH_SEED:    seed_cfg = cfg_ch.data;
          CFG_BUCKET_COUNT: buckets_cfg = cfg_ch.data[NB_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        hash_key_beat(in_ch.key_byte, in_ch.key_length, in_ch.last_byte);
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin : result_checker
    bucket_pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, hash %h",
                                  out_ch.full_hash));
      end else begin
        want = pending_buckets.pop_front();
        if (out_ch.full_hash !== want.full_hash)
          report_mismatch($sformatf("full_hash %h, expected %h",
                                    out_ch.full_hash, want.full_hash));
        if (out_ch.bucket_index !== want.bucket_index)
          report_mismatch($sformatf("bucket_index %0d, expected %0d (hash %h)",
                                    out_ch.bucket_index, want.bucket_index, want.full_hash));
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left     = 0;
      hold_off_left  = 0;
      hold_off_taken = 0;
    end else if (hold_off_taken != hold_off_reqs) begin
      hold_off_taken = hold_off_reqs;
      hold_off_left  = HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Offer one key beat and wait for it to be taken. Valid stays high after
  // the beat so that a following beat with no gap does not drop it.
  task automatic send_key_beat(input logic [BYTE_W-1:0] kb, input logic [LEN_W-1:0] klen,
                               input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_byte   <= kb;
    in_ch.key_length <= klen;
    in_ch.last_byte  <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Send a whole key; the length field only matters on the first beat.
  task automatic send_key(input key_bytes_t bytes, input logic [LEN_W-1:0] declared_len);
    foreach (bytes[i]) begin
      send_key_beat(bytes[i], (i == 0) ? declared_len : LEN_W'($urandom),
                    i == bytes.size() - 1);
      // The unhashed lead byte of a zero-length key that goes on is not counted.
      if (!(i == 0 && declared_len == '0 && bytes.size() > 1)) items_sent++;
    end
  endtask

  // Mostly well-formed keys, with empty keys, wrong lengths and keys whose
  // declared length is zero although more bytes follow.
  task automatic send_random_key();
    key_bytes_t        bytes;
    int unsigned       kind;
    int unsigned       n;
    logic [LEN_W-1:0]  declared;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      n        = 1;
      declared = '0;
    end else if (kind < 75) begin
      n        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      declared = LEN_W'(n);
    end else if (kind < 88) begin
      n        = $urandom_range(1, 10);
      declared = LEN_W'($urandom);
    end else begin
      n        = $urandom_range(2, 9);
      declared = '0;
    end
    repeat (n) bytes.push_back(BYTE_W'($urandom));
    send_key(bytes, declared);
  endtask

  task automatic send_keys(input int unsigned n_items);
    int unsigned stop;
    stop = items_sent + n_items;
    while (items_sent < stop) send_random_key();
  endtask

  // One register write; valid is left high for a write that follows at once.
  task automatic write_reg(input cfg_reg_t idx, input logic [HASH_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input logic [HASH_W-1:0] seed, input logic [HASH_W-1:0] nb_word);
    write_reg(CFG_HASH_SEED, seed);
    write_reg(CFG_BUCKET_COUNT, nb_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering beats, wait for every pending result, then let the block settle.
  // It first waits on the clock, so that the model has queued the final beat's result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Corner keys under the reset settings of seed and bucket count.
  task automatic test_directed_keys();
    key_bytes_t bytes;
    bytes = {8'h5A};                             send_key(bytes, 16'd0);
    bytes = {8'h00};                             send_key(bytes, 16'd1);
    bytes = {8'hFF};                             send_key(bytes, 16'd1);
    bytes = {8'h01, 8'h02, 8'h03};               send_key(bytes, 16'd3);
    bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};        send_key(bytes, 16'd4);
    bytes = {8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h01}; send_key(bytes, 16'd5);
    // Zero length on the first beat, but more bytes follow.
    bytes = {8'h99, 8'h10, 8'h20};               send_key(bytes, 16'd0);
    // Declared length far longer, then shorter, than the bytes sent.
    bytes = {8'h11, 8'h22};                      send_key(bytes, 16'hFFFF);
    bytes = {8'hAB, 8'hCD, 8'hEF, 8'h12, 8'h34}; send_key(bytes, 16'd2);
    drain();
  endtask

  // Extreme seeds, zero and oversized bucket counts.
  task automatic test_config_extremes();
    for (int i = 0; i < 7; i++) begin
      set_config(EDGE_SEEDS[i], EDGE_BUCKETS[i]);
      send_keys(60);
      drain();
    end
  endtask

  // Back-to-back beats with the receiver always ready.
  task automatic test_steady_flow();
    steady_flow = 1'b1;
    set_config($urandom, $urandom_range(1, 65536));
    send_keys(150);
    drain();
    steady_flow = 1'b0;
  endtask

  // Long receiver hold-off while keys keep coming, so the input backs up.
  task automatic test_result_stall();
    set_config($urandom, $urandom_range(1, 4096));
    hold_off_reqs++;
    send_keys(60);
    drain();
  endtask

  // Random keys in phases, each with its own seed and bucket count.
  task automatic test_random_keys();
    logic [HASH_W-1:0] nb;
    int unsigned       chunk;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       nb = $urandom_range(1, 16);
        1:       nb = 32'd1 << $urandom_range(0, 16);
        2:       nb = $urandom_range(1, 65536);
        default: nb = $urandom_range(0, 131071);
      endcase
      // The last phase is cut short so that the total stays near the target.
      chunk = ITEM_TARGET - items_sent;
      if (chunk > 200) chunk = 200;
      set_config($urandom, nb);
      send_keys(chunk);
      drain();
    end
  endtask

  initial begin : test_sequence
    in_ch.valid      = 1'b0;
    in_ch.key_byte   = '0;
    in_ch.key_length = '0;
    in_ch.last_byte  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_HASH_SEED;
    cfg_ch.data      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_keys();
    test_config_extremes();
    test_steady_flow();
    test_result_stall();
    test_random_keys();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Hang guard, well beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
